>>> hdl/esp_pkg.sv
// ----------------------------------------------------------------------------
// esp_pkg: shared constants and types for the equal step pitch generator
// Field widths, fixed-point format, register indexes and queue entry types.
// ----------------------------------------------------------------------------
package esp_pkg;

  localparam int unsigned FRAC_BITS    = 28;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned REF_W        = 21;
  localparam int unsigned STEPS_W      = 10;
  localparam int unsigned PITCH_W      = 22;
  localparam int unsigned SERIES_TERMS = 24;
  localparam int unsigned QDEPTH       = 4;
  localparam int unsigned QPTR_W       = 2;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 21;

  // exp2 series terms and partial sums
  localparam int unsigned TERM_W = FRAC_BITS + 1;
  localparam int unsigned SUM_W  = FRAC_BITS + 2;

  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

  localparam logic [REF_W-1:0]   REF_RST   = 21'd44000;
  localparam logic [STEPS_W-1:0] STEPS_RST = 10'd12;
  localparam logic [PITCH_W-1:0] PITCH_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_PITCH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS     = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic             oor;
    logic             ip;
    logic [IDX_W-1:0] r;
  } job_t;

  // per-stage control carried along the back pipeline
  typedef struct packed {
    logic v;
    logic oor;
    logic ip;
  } tag_t;

endpackage

>>> hdl/esp_if.sv
// ----------------------------------------------------------------------------
// esp_in_if / esp_out_if: valid/ready channels of the pitch generator
// Input carries a step index, output a pitch and an out-of-range flag.
// ----------------------------------------------------------------------------
interface esp_in_if;
  logic                      valid;
  logic                      ready;
  logic [esp_pkg::IDX_W-1:0] step_index;
  modport source (output valid, output step_index, input ready);
  modport sink   (input valid, input step_index, output ready);
endinterface

interface esp_out_if;
  logic                        valid;
  logic                        ready;
  logic [esp_pkg::PITCH_W-1:0] pitch_centihz;
  logic                        out_of_range;
  modport source (output valid, output pitch_centihz, output out_of_range, input ready);
  modport sink   (input valid, input pitch_centihz, input out_of_range, output ready);
endinterface

>>> hdl/esp_front.sv
// ----------------------------------------------------------------------------
// esp_front: input acceptance and step classification
// Split the index into octave and remainder, flag indexes past the octave.
// ----------------------------------------------------------------------------
module esp_front (
  esp_in_if.sink                      in_if,
  input  logic [esp_pkg::STEPS_W-1:0] steps_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output esp_pkg::job_t               push_job_o
);
  import esp_pkg::*;

  logic is_top;

  assign in_if.ready  = push_ready_i;
  assign push_valid_o = in_if.valid;

  // index equal to steps lands exactly on the next octave
  assign is_top          = (in_if.step_index == steps_i);
  assign push_job_o.oor  = (in_if.step_index > steps_i);
  assign push_job_o.ip   = is_top;
  assign push_job_o.r    = is_top ? '0 : in_if.step_index;

endmodule

>>> hdl/esp_queue.sv
// ----------------------------------------------------------------------------
// esp_queue: short FIFO between front and back
// Decouple input acceptance from back pipeline stalls.
// ----------------------------------------------------------------------------
module esp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  esp_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output esp_pkg::job_t pop_job_o
);
  import esp_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != (QPTR_W+1)'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_job_o    = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_job_i;
  end

endmodule

>>> hdl/esp_back.sv
// ----------------------------------------------------------------------------
// esp_back: pitch computation pipeline
// Radix-2 divider, ln2 scaling, exp2 series, reference multiply and rounding.
// ----------------------------------------------------------------------------
module esp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [esp_pkg::STEPS_W-1:0] steps_i,
  input  logic [esp_pkg::REF_W-1:0]   ref_pitch_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  esp_pkg::job_t               pop_job_i,
  esp_out_if.source                   out_if
);
  import esp_pkg::*;

  logic en;
  tag_t out_tag_q;

  // whole pipeline advances unless the output register is held
  assign en          = !out_tag_q.v || out_if.ready;
  assign pop_ready_o = en;

  // ---------------- divider: xf = r * 2^FRAC_BITS / steps ----------------
  tag_t                 div_tag_q [FRAC_BITS+1];
  logic [STEPS_W-1:0]   div_rem_q [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] div_quo_q [FRAC_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_tag_q[0] <= '0;
    end else if (en) begin
      div_tag_q[0] <= '{v: pop_valid_i, oor: pop_job_i.oor, ip: pop_job_i.ip};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_rem_q[0] <= pop_job_i.r;
      div_quo_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
    logic [STEPS_W:0] dbl;
    logic             ge;
    assign dbl = {div_rem_q[j], 1'b0};
    assign ge  = (dbl >= {1'b0, steps_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_tag_q[j+1] <= '0;
      end else if (en) begin
        div_tag_q[j+1] <= div_tag_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_rem_q[j+1] <= ge ? STEPS_W'(dbl - {1'b0, steps_i}) : dbl[STEPS_W-1:0];
        div_quo_q[j+1] <= {div_quo_q[j][FRAC_BITS-2:0], ge};
      end
    end
  end

  // ---------------- t = floor(xf * ln2) via two partial products ----------
  tag_t                  m1_tag_q;
  logic [FRAC_BITS+31:0] m1_lo_q, m1_hi_q;
  logic [FRAC_BITS+32:0] m2_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_tag_q <= '0;
    end else if (en) begin
      m1_tag_q <= div_tag_q[FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_lo_q <= (FRAC_BITS+32)'(div_quo_q[FRAC_BITS]) * (FRAC_BITS+32)'(LN2_Q64[31:0]);
      m1_hi_q <= (FRAC_BITS+32)'(div_quo_q[FRAC_BITS]) * (FRAC_BITS+32)'(LN2_Q64[63:32]);
    end
  end

  assign m2_sum = (FRAC_BITS+33)'(m1_hi_q) + (FRAC_BITS+33)'(m1_lo_q[FRAC_BITS+31:32]);

  // ---------------- exp2 series, three stages per term -------------------
  tag_t                 ser_tag_q  [SERIES_TERMS+1];
  logic [FRAC_BITS-1:0] ser_t_q    [SERIES_TERMS+1];
  logic [TERM_W-1:0]    ser_term_q [SERIES_TERMS+1];
  logic [SUM_W-1:0]     ser_sum_q  [SERIES_TERMS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_tag_q[0] <= '0;
    end else if (en) begin
      ser_tag_q[0] <= m1_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ser_t_q[0]    <= m2_sum[FRAC_BITS+31:32];
      ser_term_q[0] <= TERM_W'(1) << FRAC_BITS;
      ser_sum_q[0]  <= SUM_W'(1) << FRAC_BITS;
    end
  end

  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_ser
    localparam int unsigned K = k;
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K);

    tag_t                 a_tag_q, b_tag_q;
    logic [TERM_W-1:0]    a_p_q, b_p_q, b_q0_q, q_fix;
    logic [FRAC_BITS-1:0] a_t_q, b_t_q;
    logic [SUM_W-1:0]     a_sum_q, b_sum_q;
    logic [2*TERM_W-1:0]  prod_a;
    logic [TERM_W-1:0]    q0;
    logic [TERM_W+5:0]    rem;

    assign prod_a = (2*TERM_W)'(ser_term_q[k-1]) * (2*TERM_W)'(ser_t_q[k-1]);

    if (K == 1) begin : g_one
      assign q0 = a_p_q;
    end else begin : g_div_k
      logic [TERM_W+31:0] prod_b;
      assign prod_b = (TERM_W+32)'(a_p_q) * (TERM_W+32)'(RECIP);
      assign q0     = prod_b[TERM_W+31:32];
    end

    // estimate is at most one low; fix it with one compare
    assign rem   = (TERM_W+6)'(b_p_q) - (TERM_W+6)'(b_q0_q) * (TERM_W+6)'(K);
    assign q_fix = (rem >= (TERM_W+6)'(K)) ? b_q0_q + 1'b1 : b_q0_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_tag_q      <= '0;
        b_tag_q      <= '0;
        ser_tag_q[k] <= '0;
      end else if (en) begin
        a_tag_q      <= ser_tag_q[k-1];
        b_tag_q      <= a_tag_q;
        ser_tag_q[k] <= b_tag_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        a_p_q         <= prod_a[FRAC_BITS+TERM_W-1:FRAC_BITS];
        a_t_q         <= ser_t_q[k-1];
        a_sum_q       <= ser_sum_q[k-1];
        b_p_q         <= a_p_q;
        b_q0_q        <= q0;
        b_t_q         <= a_t_q;
        b_sum_q       <= a_sum_q;
        ser_t_q[k]    <= b_t_q;
        ser_term_q[k] <= q_fix;
        ser_sum_q[k]  <= b_sum_q + SUM_W'(q_fix);
      end
    end
  end

  // ---------------- reference multiply, rounding, output register --------
  tag_t                   f1_tag_q;
  logic [REF_W+SUM_W-1:0] f1_prod_q;
  logic [REF_W+SUM_W:0]   rnd;
  logic [REF_W+SUM_W:0]   shifted;
  logic [PITCH_W-1:0]     pitch;
  logic [PITCH_W-1:0]     pitch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_tag_q  <= '0;
      out_tag_q <= '0;
    end else if (en) begin
      f1_tag_q  <= ser_tag_q[SERIES_TERMS];
      out_tag_q <= f1_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_prod_q <= (REF_W+SUM_W)'(ref_pitch_i) * (REF_W+SUM_W)'(ser_sum_q[SERIES_TERMS]);
      pitch_q   <= pitch;
    end
  end

  // round half up at 2^(FRAC_BITS-ip)
  always_comb begin
    if (f1_tag_q.ip) begin
      rnd     = (REF_W+SUM_W+1)'(f1_prod_q) + ((REF_W+SUM_W+1)'(1) << (FRAC_BITS-2));
      shifted = rnd >> (FRAC_BITS-1);
    end else begin
      rnd     = (REF_W+SUM_W+1)'(f1_prod_q) + ((REF_W+SUM_W+1)'(1) << (FRAC_BITS-1));
      shifted = rnd >> FRAC_BITS;
    end
    if (f1_tag_q.oor) begin
      pitch = '0;
    end else if (shifted > (REF_W+SUM_W+1)'(PITCH_MAX)) begin
      pitch = PITCH_MAX;
    end else begin
      pitch = shifted[PITCH_W-1:0];
    end
  end

  assign out_if.valid         = out_tag_q.v;
  assign out_if.out_of_range  = out_tag_q.oor;
  assign out_if.pitch_centihz = pitch_q;

endmodule

>>> hdl/equal_step_pitch_generator.sv
// ----------------------------------------------------------------------------
// equal_step_pitch_generator: frequency of one step of an equal octave split
// Top level: configuration registers, front, queue and compute pipeline.
// ----------------------------------------------------------------------------
// Returns reference_pitch * 2^(step_index / steps_per_octave) in centihertz,
// rounded to nearest with ties up, with 28 fractional bits inside. One step
// index is taken per clock and one result leaves per clock while out_if.ready
// does not hold the output register. An item passes the queue, a 28-stage
// radix-2 divider, two ln2 multiply stages, 24 series terms of three stages
// each, then reference multiply and rounding. An index above the step count
// gives pitch 0 with out_of_range set. A step count of zero acts as one.
// Write the registers only while no item is in flight.
// ----------------------------------------------------------------------------
module equal_step_pitch_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [esp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [esp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  esp_in_if.sink                         in_if,
  esp_out_if.source                      out_if
);
  import esp_pkg::*;

  logic [REF_W-1:0]   ref_pitch_q;
  logic [STEPS_W-1:0] steps_q;
  logic [STEPS_W-1:0] steps_eff;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_pitch_q <= REF_RST;
      steps_q     <= STEPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REF_PITCH: ref_pitch_q <= cfg_data_i[REF_W-1:0];
        CFG_STEPS:     steps_q     <= cfg_data_i[STEPS_W-1:0];
        default:       ;
      endcase
    end
  end

  // zero steps per octave acts as one step
  assign steps_eff = (steps_q == '0) ? STEPS_W'(1) : steps_q;

  // classify and transfer into the queue
  esp_front u_front (
    .in_if        (in_if),
    .steps_i      (steps_eff),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // hold classified items while the pipeline is stalled
  esp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // compute the pitch and drive the output register
  esp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .steps_i     (steps_eff),
    .ref_pitch_i (ref_pitch_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_if      (out_if)
  );

endmodule
